[sv/gtd_pkg.sv]
package gtd_pkg;

    // Item command codes
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_SAMPLE = 2'd0;
    localparam t_cmd CMD_START  = 2'd1;
    localparam t_cmd CMD_STOP   = 2'd2;

    // Detector mode codes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_IDLE   = 2'd0;
    localparam t_mode MODE_SEARCH = 2'd1;
    localparam t_mode MODE_DETECT = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IR_CHANNEL    = 3'd0;
    localparam t_cfg_idx CFG_LEFT_CHANNEL  = 3'd1;
    localparam t_cfg_idx CFG_MID_CHANNEL   = 3'd2;
    localparam t_cfg_idx CFG_RIGHT_CHANNEL = 3'd3;
    localparam t_cfg_idx CFG_COEFF_LOW     = 3'd4;
    localparam t_cfg_idx CFG_COEFF_HIGH    = 3'd5;
    localparam t_cfg_idx CFG_THR_LOW       = 3'd6;
    localparam t_cfg_idx CFG_THR_HIGH      = 3'd7;

    // Shared multiplier operand selection
    typedef logic [1:0] t_mul_op;
    localparam t_mul_op MUL_C_S1  = 2'd0;
    localparam t_mul_op MUL_C_S2  = 2'd1;
    localparam t_mul_op MUL_U_S1  = 2'd2;
    localparam t_mul_op MUL_S2_S2 = 2'd3;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  channel;
        logic [11:0] raw_sample;
        logic        tone_select;
    } t_in_item;

    typedef struct packed {
        t_mode       detector_state;
        logic        window_done;
        logic [47:0] magnitude_sq;
        logic [3:0]  hit_count;
        logic [11:0] line_left;
        logic [11:0] line_mid;
        logic [11:0] line_right;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    apply;
        logic    mul_en;
        t_mul_op mul_op;
        logic [1:0] digit;
        logic    upd;
        logic    make_u;
        logic    acc_en;
        logic    finish;
        logic    emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_rec;
        logic win_last;
        logic out_free;
    } t_dp_sts;

    // 17-bit signed digit of a 40-bit signed operand: two unsigned, one signed
    function automatic logic signed [16:0] mul_digit(input logic [39:0] b,
                                                     input logic [1:0] k);
        logic signed [16:0] d;
        case (k)
            2'd0:    d = {1'b0, b[15:0]};
            2'd1:    d = {1'b0, b[31:16]};
            default: d = {{9{b[39]}}, b[39:32]};
        endcase
        return d;
    endfunction

endpackage

[sv/gtd_in_if.sv]
interface gtd_in_if;
    import gtd_pkg::*;

    logic        valid;
    logic        ready;
    t_cmd        cmd;
    logic [3:0]  channel;
    logic [11:0] raw_sample;
    logic        tone_select;

    modport source (output valid, output cmd, output channel, output raw_sample,
                    output tone_select, input ready);
    modport sink (input valid, input cmd, input channel, input raw_sample,
                  input tone_select, output ready);
endinterface

[sv/gtd_out_if.sv]
interface gtd_out_if;
    import gtd_pkg::*;

    logic        valid;
    logic        ready;
    t_mode       detector_state;
    logic        window_done;
    logic [47:0] magnitude_sq;
    logic [3:0]  hit_count;
    logic [11:0] line_left;
    logic [11:0] line_mid;
    logic [11:0] line_right;

    modport source (output valid, output detector_state, output window_done,
                    output magnitude_sq, output hit_count, output line_left,
                    output line_mid, output line_right, input ready);
    modport sink (input valid, input detector_state, input window_done,
                  input magnitude_sq, input hit_count, input line_left,
                  input line_mid, input line_right, output ready);
endinterface

[sv/goertzel_tone_detector_unit.sv]
// Channel   Dir  Handshake          Payload
// i_in      in   valid/ready        cmd, channel, raw_sample, tone_select
// o_out     out  valid/ready        detector_state, window_done, magnitude_sq,
//                                   hit_count, line_left, line_mid, line_right
// i_cfg     in   write enable only  i_cfg_idx, i_cfg_data
//
// An item passes from transfer to result through decode; an IR sample while searching also
// makes one pass through the shared 58x17 multiplier. The sample that closes a window is also
// evaluated: six 17-bit digit products through the same multiplier build the magnitude.
// Synchronous active-low reset returns the detector to idle with reset configuration.
// A new item is taken while the previous result still waits in the output register;
// the result of that item is held until the output side takes the waiting one.
module goertzel_tone_detector_unit #(
    parameter int WINDOW_SIZE     = 256,
    parameter int CONFIRM_WINDOWS = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    gtd_in_if.sink                         i_in,
    gtd_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [gtd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gtd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gtd_pkg::*;

    t_in_item  in_item;
    t_out_item out_item;
    t_dp_cmd   dp_cmd;
    t_dp_sts   dp_sts;
    logic      in_ready;
    logic      out_valid;

    // Gather the input payload
    assign in_item.cmd         = i_in.cmd;
    assign in_item.channel     = i_in.channel;
    assign in_item.raw_sample  = i_in.raw_sample;
    assign in_item.tone_select = i_in.tone_select;
    assign i_in.ready          = in_ready;

    gtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    gtd_datapath #(
        .WINDOW_SIZE     (WINDOW_SIZE),
        .CONFIRM_WINDOWS (CONFIRM_WINDOWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (in_item),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_out_item  (out_item)
    );

    // Drive the result channel
    assign o_out.valid          = out_valid;
    assign o_out.detector_state = out_item.detector_state;
    assign o_out.window_done    = out_item.window_done;
    assign o_out.magnitude_sq   = out_item.magnitude_sq;
    assign o_out.hit_count      = out_item.hit_count;
    assign o_out.line_left      = out_item.line_left;
    assign o_out.line_mid       = out_item.line_mid;
    assign o_out.line_right     = out_item.line_right;

endmodule

[sv/gtd_ctrl.sv]
module gtd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  gtd_pkg::t_dp_sts i_sts,
    output gtd_pkg::t_dp_cmd o_cmd
);
    import gtd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_REC    = 4'd2;
    localparam logic [3:0] S_EVAL0  = 4'd3;
    localparam logic [3:0] S_EVAL1  = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_ACC    = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_digit, n_digit;
    logic       r_phase, n_phase;

    assign o_in_ready = (r_state == S_IDLE);

    // Sequence one item through decode, recurrence, window evaluation and emit
    always_comb begin
        n_state = r_state;
        n_digit = r_digit;
        n_phase = r_phase;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.apply = 1'b1;
                if (i_sts.need_rec) begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.mul_op = MUL_C_S1;
                    n_state      = S_REC;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_REC: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.win_last ? S_EVAL0 : S_EMIT;
            end
            S_EVAL0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_C_S2;
                n_state      = S_EVAL1;
            end
            S_EVAL1: begin
                o_cmd.make_u = 1'b1;
                n_digit      = 2'd0;
                n_phase      = 1'b0;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = r_phase ? MUL_S2_S2 : MUL_U_S1;
                o_cmd.digit  = r_digit;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                if (r_digit == 2'd2) begin
                    n_digit = 2'd0;
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_digit = r_digit + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_digit <= 2'd0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_digit <= n_digit;
            r_phase <= n_phase;
        end
    end

    a_load_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_DECODE)
        else $error("transfer accepted but decode did not follow");

    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ACC |-> $past(r_state) == S_MUL)
        else $error("accumulate without a preceding multiply");

    a_fin_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> $past(r_state) == S_ACC && $past(r_phase) && $past(r_digit) == 2'd2)
        else $error("window finished before all partial products");

endmodule

[sv/gtd_datapath.sv]
module gtd_datapath #(
    parameter int WINDOW_SIZE     = 256,
    parameter int CONFIRM_WINDOWS = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gtd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gtd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  gtd_pkg::t_in_item                  i_item,
    input  gtd_pkg::t_dp_cmd                   i_cmd,
    output gtd_pkg::t_dp_sts                   o_sts,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output gtd_pkg::t_out_item                 o_out_item
);
    import gtd_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_SIZE - 1);
    localparam logic [3:0] CONFIRM = 4'(CONFIRM_WINDOWS);
    localparam logic signed [45:0] SAT_HI = 46'sd549755813887;
    localparam logic signed [45:0] SAT_LO = -46'sd549755813888;

    // Configuration registers
    logic [3:0]         r_ir_ch, r_left_ch, r_mid_ch, r_right_ch;
    logic signed [16:0] r_coeff_low, r_coeff_high;
    logic [47:0]        r_thr_low, r_thr_high;

    // Detector state
    t_in_item           r_item;
    t_mode              r_mode;
    logic signed [39:0] r_d1, r_d2;
    logic [CNT_W-1:0]   r_count;
    logic [3:0]         r_streak;
    logic signed [16:0] r_coeff;
    logic [47:0]        r_thr;
    logic [47:0]        r_mag;
    logic [11:0]        r_line_l, r_line_m, r_line_r;
    logic               r_done;

    // Arithmetic registers
    logic signed [74:0] r_prod;
    logic [1:0]         r_prod_dig;
    logic signed [57:0] r_u;
    logic signed [99:0] r_acc;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               ir_hit;
    logic signed [57:0] mul_a;
    logic signed [16:0] mul_d;
    logic signed [74:0] mul_p;
    logic signed [12:0] x13;
    logic signed [57:0] rnd_t, rnd;
    logic signed [45:0] sum46;
    logic signed [39:0] s_new;
    logic signed [57:0] u_next;
    logic signed [99:0] prod_ext, prod_sh;
    logic [47:0]        mag_next;
    logic [3:0]         streak_inc;

    assign ir_hit         = (r_item.channel == r_ir_ch);
    assign o_sts.need_rec = (r_item.cmd == CMD_SAMPLE) && (r_mode == MODE_SEARCH) && ir_hit;
    assign o_sts.win_last = (r_count == CNT_LAST);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Select the shared multiplier operands
    always_comb begin
        case (i_cmd.mul_op)
            MUL_C_S1: begin
                mul_a = {{18{r_d1[39]}}, r_d1};
                mul_d = r_coeff;
            end
            MUL_C_S2: begin
                mul_a = {{18{r_d2[39]}}, r_d2};
                mul_d = r_coeff;
            end
            MUL_U_S1: begin
                mul_a = r_u;
                mul_d = mul_digit(r_d1, i_cmd.digit);
            end
            default: begin
                mul_a = {{4{r_d2[39]}}, r_d2, 14'b0};
                mul_d = mul_digit(r_d2, i_cmd.digit);
            end
        endcase
        mul_p = mul_a * mul_d;
    end

    // Recurrence: s = x + round(coeff*s1 / 2^14) - s2 with x = raw_sample - 2048, saturated to 40 bits
    always_comb begin
        x13   = $signed({1'b0, r_item.raw_sample}) - 13'sd2048;
        rnd_t = r_prod[57:0] + 58'sd8192;
        rnd   = rnd_t >>> 14;
        sum46 = {{33{x13[12]}}, x13} + rnd[45:0] - {{6{r_d2[39]}}, r_d2};
        if (sum46 > SAT_HI) begin
            s_new = {1'b0, {39{1'b1}}};
        end else if (sum46 < SAT_LO) begin
            s_new = {1'b1, 39'b0};
        end else begin
            s_new = sum46[39:0];
        end
    end

    // Window evaluation: u = s1*2^14 - coeff*s2, then acc = s1*u + s2*s2*2^14 + half
    always_comb begin
        u_next   = {{4{r_d1[39]}}, r_d1, 14'b0} - r_prod[57:0];
        prod_ext = {{25{r_prod[74]}}, r_prod};
        case (r_prod_dig)
            2'd0:    prod_sh = prod_ext;
            2'd1:    prod_sh = {prod_ext[83:0], 16'b0};
            default: prod_sh = {prod_ext[67:0], 32'b0};
        endcase
        if (r_acc[99]) begin
            mag_next = '0;
        end else if (|r_acc[98:62]) begin
            mag_next = '1;
        end else begin
            mag_next = r_acc[61:14];
        end
        streak_inc = (r_streak == 4'd15) ? r_streak : r_streak + 4'd1;
    end

    // Configuration and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir_ch      <= 4'd0;
            r_left_ch    <= 4'd1;
            r_mid_ch     <= 4'd2;
            r_right_ch   <= 4'd3;
            r_coeff_low  <= 17'sd32768;
            r_coeff_high <= 17'sd32768;
            r_thr_low    <= '1;
            r_thr_high   <= '1;
            r_mode       <= MODE_IDLE;
            r_d1         <= '0;
            r_d2         <= '0;
            r_count      <= '0;
            r_streak     <= '0;
            r_coeff      <= '0;
            r_thr        <= '1;
            r_mag        <= '0;
            r_line_l     <= '0;
            r_line_m     <= '0;
            r_line_r     <= '0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IR_CHANNEL:    r_ir_ch      <= i_cfg_data[3:0];
                    CFG_LEFT_CHANNEL:  r_left_ch    <= i_cfg_data[3:0];
                    CFG_MID_CHANNEL:   r_mid_ch     <= i_cfg_data[3:0];
                    CFG_RIGHT_CHANNEL: r_right_ch   <= i_cfg_data[3:0];
                    CFG_COEFF_LOW:     r_coeff_low  <= i_cfg_data[16:0];
                    CFG_COEFF_HIGH:    r_coeff_high <= i_cfg_data[16:0];
                    CFG_THR_LOW:       r_thr_low    <= i_cfg_data[47:0];
                    CFG_THR_HIGH:      r_thr_high   <= i_cfg_data[47:0];
                    default: ;
                endcase
            end
            if (i_cmd.apply) begin
                r_done <= 1'b0;
                case (r_item.cmd)
                    CMD_START: begin
                        r_coeff  <= r_item.tone_select ? r_coeff_low : r_coeff_high;
                        r_thr    <= r_item.tone_select ? r_thr_low : r_thr_high;
                        r_d1     <= '0;
                        r_d2     <= '0;
                        r_count  <= '0;
                        r_streak <= '0;
                        r_mag    <= '0;
                        r_mode   <= MODE_SEARCH;
                    end
                    CMD_STOP: begin
                        r_mode <= MODE_IDLE;
                    end
                    CMD_SAMPLE: begin
                        // IR channel wins, then left, mid and right
                        if (r_mode != MODE_IDLE && !ir_hit) begin
                            if (r_item.channel == r_left_ch) begin
                                r_line_l <= r_item.raw_sample;
                            end else if (r_item.channel == r_mid_ch) begin
                                r_line_m <= r_item.raw_sample;
                            end else if (r_item.channel == r_right_ch) begin
                                r_line_r <= r_item.raw_sample;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.upd) begin
                r_d2    <= r_d1;
                r_d1    <= s_new;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_mag <= mag_next;
                if (mag_next >= r_thr) begin
                    r_streak <= streak_inc;
                    if (streak_inc >= CONFIRM) begin
                        r_mode <= MODE_DETECT;
                    end
                end else begin
                    r_streak <= '0;
                end
                r_d1    <= '0;
                r_d2    <= '0;
                r_count <= '0;
                r_done  <= 1'b1;
            end
        end
    end

    // Item capture, product and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.mul_en) begin
            r_prod     <= mul_p;
            r_prod_dig <= i_cmd.digit;
        end
        if (i_cmd.make_u) begin
            r_u   <= u_next;
            r_acc <= 100'sd8192;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + prod_sh;
        end
    end

    // Output register: load on emit, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.detector_state <= r_mode;
            r_out.window_done    <= r_done;
            r_out.magnitude_sq   <= r_mag;
            r_out.hit_count      <= r_streak;
            r_out.line_left      <= r_line_l;
            r_out.line_mid       <= r_line_m;
            r_out.line_right     <= r_line_r;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_detect_streak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_DETECT |-> r_streak >= CONFIRM)
        else $error("detected without a full streak");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_count == '0 && r_done)
        else $error("window not cleared after evaluation");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import gtd_pkg::*;

    localparam int          WINDOW_SIZE     = 256;
    localparam int          CONFIRM_WINDOWS = 3;
    localparam t_cmd        CMD_UNUSED      = 2'd3;
    localparam longint      DELAY_MAX       = 64'sd549755813887;
    localparam longint      DELAY_MIN       = -DELAY_MAX - 1;
    localparam logic [47:0] MAG_ALL_ONES    = 48'hFFFF_FFFF_FFFF;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          N_ITEMS         = 1600;

    // Tracks the detector state from accepted items and checks every status word
    class detector_tracker;
        logic [3:0]  ir_ch, left_ch, mid_ch, right_ch;
        longint      coeff_lo, coeff_hi;
        logic [47:0] thr_lo, thr_hi;

        t_mode       mode;
        longint      d1, d2;
        int unsigned win_cnt;
        logic [3:0]  streak;
        longint      coeff;
        logic [47:0] thr;
        logic [47:0] last_mag;
        logic [11:0] latch [3];

        t_out_item   status_due [$];
        int unsigned n_in, n_out, n_windows, n_detects, n_errors;

        function new();
            ir_ch = 4'd0; left_ch = 4'd1; mid_ch = 4'd2; right_ch = 4'd3;
            coeff_lo = 32768; coeff_hi = 32768;
            thr_lo = MAG_ALL_ONES; thr_hi = MAG_ALL_ONES;
            mode = MODE_IDLE;
            d1 = 0; d2 = 0; win_cnt = 0; streak = 4'd0;
            coeff = 0; thr = MAG_ALL_ONES; last_mag = 48'd0;
            foreach (latch[i]) latch[i] = 12'd0;
            n_in = 0; n_out = 0; n_windows = 0; n_detects = 0; n_errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [47:0] data);
            case (idx)
                CFG_IR_CHANNEL:    ir_ch    = data[3:0];
                CFG_LEFT_CHANNEL:  left_ch  = data[3:0];
                CFG_MID_CHANNEL:   mid_ch   = data[3:0];
                CFG_RIGHT_CHANNEL: right_ch = data[3:0];
                CFG_COEFF_LOW:     coeff_lo = longint'($signed(data[16:0]));
                CFG_COEFF_HIGH:    coeff_hi = longint'($signed(data[16:0]));
                CFG_THR_LOW:       thr_lo   = data;
                CFG_THR_HIGH:      thr_hi   = data;
                default: ;
            endcase
        endfunction

        // Exact squared magnitude of the closing window, clamped to 48 bits
        function logic [47:0] window_energy();
            logic signed [127:0] a, b, c, t;
            a = d1;
            b = d2;
            c = coeff;
            t = ((a * a + b * b) <<< 14) - c * a * b + 8192;
            if (t < 0)
                return 48'd0;
            if (t >= (128'sd1 <<< 62))
                return MAG_ALL_ONES;
            return t[61:14];
        endfunction

        // Advance the detector by one accepted item and queue its status word
        function void take_item(t_in_item it);
            t_out_item want;
            logic      done;
            longint    x, s;
            done = 1'b0;
            n_in++;
            if (it.cmd == CMD_START) begin
                coeff    = it.tone_select ? coeff_lo : coeff_hi;
                thr      = it.tone_select ? thr_lo : thr_hi;
                d1 = 0; d2 = 0; win_cnt = 0;
                streak   = 4'd0;
                last_mag = 48'd0;
                mode     = MODE_SEARCH;
            end else if (it.cmd == CMD_STOP) begin
                mode = MODE_IDLE;
            end else if (it.cmd == CMD_SAMPLE && mode != MODE_IDLE) begin
                if (it.channel == ir_ch) begin
                    if (mode == MODE_SEARCH) begin
                        x = longint'(it.raw_sample) - 2048;
                        s = x + ((coeff * d1 + 8192) >>> 14) - d2;
                        if (s > DELAY_MAX)
                            s = DELAY_MAX;
                        else if (s < DELAY_MIN)
                            s = DELAY_MIN;
                        d2 = d1;
                        d1 = s;
                        win_cnt++;
                        if (win_cnt >= WINDOW_SIZE) begin
                            last_mag = window_energy();
                            if (last_mag >= thr) begin
                                if (streak < 4'd15)
                                    streak++;
                                if (streak >= CONFIRM_WINDOWS) begin
                                    mode = MODE_DETECT;
                                    n_detects++;
                                end
                            end else begin
                                streak = 4'd0;
                            end
                            d1 = 0; d2 = 0; win_cnt = 0;
                            done = 1'b1;
                            n_windows++;
                        end
                    end
                end else if (it.channel == left_ch) begin
                    latch[0] = it.raw_sample;
                end else if (it.channel == mid_ch) begin
                    latch[1] = it.raw_sample;
                end else if (it.channel == right_ch) begin
                    latch[2] = it.raw_sample;
                end
            end
            want.detector_state = mode;
            want.window_done    = done;
            want.magnitude_sq   = last_mag;
            want.hit_count      = streak;
            want.line_left      = latch[0];
            want.line_mid       = latch[1];
            want.line_right     = latch[2];
            status_due.push_back(want);
        endfunction

        // Compare one status transfer with the oldest queued word
        function void check_status(t_out_item got);
            t_out_item want;
            string     bad;
            n_out++;
            if (status_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("status %0d arrived with nothing queued: state=%0d done=%0b mag=%h",
                             n_out, got.detector_state, got.window_done, got.magnitude_sq);
                return;
            end
            want = status_due.pop_front();
            bad  = "";
            if (got.detector_state !== want.detector_state) bad = {bad, " state"};
            if (got.window_done    !== want.window_done)    bad = {bad, " done"};
            if (got.magnitude_sq   !== want.magnitude_sq)   bad = {bad, " magnitude"};
            if (got.hit_count      !== want.hit_count)      bad = {bad, " hits"};
            if (got.line_left      !== want.line_left)      bad = {bad, " left"};
            if (got.line_mid       !== want.line_mid)       bad = {bad, " mid"};
            if (got.line_right     !== want.line_right)     bad = {bad, " right"};
            if (bad != "") begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("status %0d differs in%s", n_out, bad);
                    $display("  expected state=%0d done=%0b mag=%h hits=%0d lines=%h %h %h",
                             want.detector_state, want.window_done, want.magnitude_sq,
                             want.hit_count, want.line_left, want.line_mid, want.line_right);
                    $display("  actual   state=%0d done=%0b mag=%h hits=%0d lines=%h %h %h",
                             got.detector_state, got.window_done, got.magnitude_sq,
                             got.hit_count, got.line_left, got.line_mid, got.line_right);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [47:0] cfg_data;

    int unsigned feed_gap_pct;
    int unsigned sink_gap_pct;
    bit          hold_req;
    bit          held_once;
    int unsigned n_settings;

    detector_tracker tracker;

    gtd_in_if  in_ch ();
    gtd_out_if out_ch ();

    goertzel_tone_detector_unit #(
        .WINDOW_SIZE    (WINDOW_SIZE),
        .CONFIRM_WINDOWS(CONFIRM_WINDOWS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_in_item make_item(t_cmd c, logic [3:0] ch, logic [11:0] raw,
                                           logic sel);
        t_in_item it;
        it.cmd         = c;
        it.channel     = ch;
        it.raw_sample  = raw;
        it.tone_select = sel;
        return it;
    endfunction

    // Offer one item after random gaps and hold it until the transfer
    task automatic send_item(t_in_item it);
        // pacing follows progress: sender idles less first, then more, then neither
        if (tracker.n_in < N_ITEMS / 3) begin
            feed_gap_pct = 33; sink_gap_pct = 50;
        end else if (tracker.n_in < 2 * N_ITEMS / 3) begin
            feed_gap_pct = 50; sink_gap_pct = 33;
        end else begin
            feed_gap_pct = 0; sink_gap_pct = 0;
        end
        while ($urandom_range(99) < feed_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= it.cmd;
        in_ch.channel     <= it.channel;
        in_ch.raw_sample  <= it.raw_sample;
        in_ch.tone_select <= it.tone_select;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
        tracker.take_item(it);
    endtask

    // Drop valid and wait until every queued status word has been taken
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.status_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [47:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    function automatic logic signed [16:0] pick_coeff();
        int v;
        case ($urandom_range(9))
            0:       return 17'sh10000;
            1:       return 17'sd65535;
            2:       return 17'sd32768;
            3:       return -17'sd32768;
            default: begin
                v = int'($urandom_range(65535)) - 32768;
                return v[16:0];
            end
        endcase
    endfunction

    function automatic logic [47:0] pick_threshold();
        logic [63:0] w;
        int unsigned k;
        w = {$urandom, $urandom};
        k = $urandom_range(44, 12);
        case ($urandom_range(7))
            0:       return 48'd0;
            1:       return MAG_ALL_ONES;
            default: return w[47:0] & ((48'd1 << k) - 48'd1);
        endcase
    endfunction

    // Write every register; the first settings pin the extremes and channel overlaps
    task automatic apply_setting(int phase);
        logic [3:0]         ir, lf, md, rt;
        logic signed [16:0] c_lo, c_hi;
        logic [47:0]        t_lo, t_hi;
        case (phase)
            0: begin
                ir = 4'd0; lf = 4'd1; md = 4'd2; rt = 4'd3;
                c_lo = 17'sd32768; c_hi = 17'sh10000;
                t_lo = 48'd0; t_hi = MAG_ALL_ONES;
            end
            1: begin
                ir = 4'd15; lf = 4'd15; md = 4'd7; rt = 4'd7;
                c_lo = 17'sd65535; c_hi = 17'sd0;
                t_lo = MAG_ALL_ONES; t_hi = 48'd0;
            end
            2: begin
                ir = 4'd9; lf = 4'd4; md = 4'd9; rt = 4'd4;
                c_lo = -17'sd32768; c_hi = 17'sd32768;
                t_lo = pick_threshold(); t_hi = pick_threshold();
            end
            default: begin
                ir = 4'($urandom_range(15)); lf = 4'($urandom_range(15));
                md = 4'($urandom_range(15)); rt = 4'($urandom_range(15));
                c_lo = pick_coeff(); c_hi = pick_coeff();
                t_lo = pick_threshold(); t_hi = pick_threshold();
            end
        endcase
        put_reg(CFG_IR_CHANNEL,    {44'd0, ir});
        put_reg(CFG_LEFT_CHANNEL,  {44'd0, lf});
        put_reg(CFG_MID_CHANNEL,   {44'd0, md});
        put_reg(CFG_RIGHT_CHANNEL, {44'd0, rt});
        put_reg(CFG_COEFF_LOW,     {{31{c_lo[16]}}, c_lo});
        put_reg(CFG_COEFF_HIGH,    {{31{c_hi[16]}}, c_hi});
        put_reg(CFG_THR_LOW,       t_lo);
        put_reg(CFG_THR_HIGH,      t_hi);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // One search: some noise, a start, a long run of mostly IR samples, usually a stop
    task automatic run_session();
        int unsigned len, style, half, k, r;
        logic [11:0] lo_v, hi_v, raw;
        logic [3:0]  ch;
        t_in_item    it;
        if (!held_once) begin
            hold_req  = 1'b1;
            held_once = 1'b1;
        end
        style = $urandom_range(3);
        half  = $urandom_range(16, 1);
        k     = 0;
        case ($urandom_range(2))
            0:       begin lo_v = 12'd0;    hi_v = 12'd4095; end
            1:       begin lo_v = 12'd4095; hi_v = 12'd0;    end
            default: begin
                lo_v = 12'($urandom_range(4095));
                hi_v = 12'($urandom_range(4095));
            end
        endcase
        repeat ($urandom_range(2)) begin
            send_item(make_item(t_cmd'($urandom_range(3)), 4'($urandom_range(15)),
                                12'($urandom_range(4095)), 1'($urandom_range(1))));
        end
        send_item(make_item(CMD_START, 4'($urandom_range(15)), 12'($urandom_range(4095)),
                            1'($urandom_range(1))));
        len = $urandom_range(1100, 260);
        repeat (len) begin
            if (tracker.n_in >= N_ITEMS)
                break;
            r = $urandom_range(999);
            if (r < 2) begin
                it = make_item(CMD_START, 4'($urandom_range(15)), 12'($urandom_range(4095)),
                               1'($urandom_range(1)));
            end else if (r < 4) begin
                it = make_item(CMD_UNUSED, 4'($urandom_range(15)), 12'($urandom_range(4095)),
                               1'($urandom_range(1)));
            end else if (r < 5) begin
                it = make_item(CMD_STOP, 4'($urandom_range(15)), 12'($urandom_range(4095)),
                               1'($urandom_range(1)));
            end else if (r < 860) begin
                case (style)
                    0:       raw = 12'($urandom_range(4095));
                    1:       raw = ((k / half) % 2 != 0) ? hi_v : lo_v;
                    2:       raw = lo_v;
                    default: raw = 12'(2040 + $urandom_range(16));
                endcase
                k++;
                it = make_item(CMD_SAMPLE, tracker.ir_ch, raw, 1'($urandom_range(1)));
            end else begin
                case ($urandom_range(3))
                    0:       ch = tracker.left_ch;
                    1:       ch = tracker.mid_ch;
                    2:       ch = tracker.right_ch;
                    default: ch = 4'($urandom_range(15));
                endcase
                it = make_item(CMD_SAMPLE, ch, 12'($urandom_range(4095)),
                               1'($urandom_range(1)));
            end
            send_item(it);
        end
        if ($urandom_range(4) != 0)
            send_item(make_item(CMD_STOP, 4'($urandom_range(15)), 12'($urandom_range(4095)),
                                1'($urandom_range(1))));
    endtask

    // Status side: random stalls, one long hold-off, check each transfer
    initial begin : status_sink
        int unsigned hold_left;
        t_out_item   got;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.detector_state = out_ch.detector_state;
                got.window_done    = out_ch.window_done;
                got.magnitude_sq   = out_ch.magnitude_sq;
                got.hit_count      = out_ch.hit_count;
                got.line_left      = out_ch.line_left;
                got.line_mid       = out_ch.line_mid;
                got.line_right     = out_ch.line_right;
                tracker.check_status(got);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_gap_pct);
            end
        end
    end

    initial begin : stimulus
        int phase;
        tracker      = new();
        feed_gap_pct = 33;
        sink_gap_pct = 50;
        hold_req     = 1'b0;
        held_once    = 1'b0;
        n_settings   = 0;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_IR_CHANNEL;
        cfg_data     = 48'd0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_SAMPLE;
        in_ch.channel     = 4'd0;
        in_ch.raw_sample  = 12'd0;
        in_ch.tone_select = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items on the reset configuration
        send_item(make_item(CMD_SAMPLE, 4'd1,  12'd4095, 1'b0));  // idle sample is dropped
        send_item(make_item(CMD_STOP,   4'd0,  12'd0,    1'b1));  // stop while idle
        send_item(make_item(CMD_UNUSED, 4'd15, 12'd4095, 1'b1));  // unknown command
        send_item(make_item(CMD_START,  4'd0,  12'd0,    1'b1));
        send_item(make_item(CMD_SAMPLE, 4'd1,  12'd4095, 1'b0));
        send_item(make_item(CMD_SAMPLE, 4'd2,  12'hA5A,  1'b1));
        send_item(make_item(CMD_SAMPLE, 4'd3,  12'h5A5,  1'b0));
        send_item(make_item(CMD_SAMPLE, 4'd15, 12'd4095, 1'b1));  // unmapped channel
        send_item(make_item(CMD_SAMPLE, 4'd0,  12'd0,    1'b0));
        send_item(make_item(CMD_SAMPLE, 4'd0,  12'd4095, 1'b1));
        send_item(make_item(CMD_SAMPLE, 4'd0,  12'd2048, 1'b0));
        send_item(make_item(CMD_UNUSED, 4'd1,  12'd0,    1'b0));
        send_item(make_item(CMD_START,  4'd7,  12'd4095, 1'b0));  // restart while searching
        send_item(make_item(CMD_SAMPLE, 4'd0,  12'd4095, 1'b0));
        send_item(make_item(CMD_SAMPLE, 4'd3,  12'd0,    1'b1));
        send_item(make_item(CMD_STOP,   4'd8,  12'd1234, 1'b1));
        send_item(make_item(CMD_SAMPLE, 4'd2,  12'd0,    1'b0));
        send_item(make_item(CMD_START,  4'd0,  12'd0,    1'b1));
        send_item(make_item(CMD_STOP,   4'd0,  12'd0,    1'b0));

        // Random searches across a series of register settings
        phase = 0;
        while (tracker.n_in < N_ITEMS) begin
            drain();
            apply_setting(phase);
            repeat ($urandom_range(3, 1))
                run_session();
            phase++;
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (tracker.status_due.size() != 0) begin
            $display("%0d status words never arrived", tracker.status_due.size());
            tracker.n_errors += tracker.status_due.size();
        end
        $display("Covered %0d items in and %0d status words out over %0d register settings.",
                 tracker.n_in, tracker.n_out, n_settings);
        $display("Windows evaluated: %0d, detections: %0d, mismatches: %0d.",
                 tracker.n_windows, tracker.n_detects, tracker.n_errors);
        if (tracker.n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[goertzel_tone_detector_unit.f]
sv/gtd_pkg.sv
sv/gtd_in_if.sv
sv/gtd_out_if.sv
sv/gtd_ctrl.sv
sv/gtd_datapath.sv
sv/goertzel_tone_detector_unit.sv
bench/testbench.sv
